/* rtl/kct_pkg.sv */
package kct_pkg;

  localparam int unsigned NumKeysDef   = 10;
  localparam int unsigned KeyW         = 4;
  localparam int unsigned TickW        = 16;
  localparam int unsigned CountW       = 7;
  localparam int unsigned DigitW       = 4;
  localparam int unsigned KindW        = 2;
  localparam int unsigned CfgIdxW      = 1;

  localparam logic [TickW-1:0]  LongPressReset = 16'd256;
  localparam logic [TickW-1:0]  DoubleGapReset = 16'hB0;
  localparam logic [CountW-1:0] CountWrap      = 7'd97;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LONG_PRESS = 1'b0,
    CFG_DOUBLE_GAP = 1'b1
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_SINGLE = 2'd0,
    KIND_DOUBLE = 2'd1,
    KIND_LONG   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE       = 4'd0,
    ST_ARM        = 4'd1,
    ST_DEBOUNCE   = 4'd2,
    ST_HELD       = 4'd3,
    ST_REL_CHK    = 4'd4,
    ST_GAP        = 4'd5,
    ST_SINGLE     = 4'd6,
    ST_PRESS2_CHK = 4'd7,
    ST_DOUBLE     = 4'd8,
    ST_WAIT_REL_D = 4'd9,
    ST_REL_D_CHK  = 4'd10,
    ST_LONG       = 4'd11,
    ST_WAIT_REL_L = 4'd12,
    ST_REL_L_CHK  = 4'd13,
    ST_DONE       = 4'd14
  } state_e;

  typedef struct packed {
    logic [TickW-1:0] long_press;
    logic [TickW-1:0] double_gap;
  } cfg_t;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [KeyW-1:0] key;
  } emit_t;

  typedef struct packed {
    logic [DigitW-1:0] tens;
    logic [DigitW-1:0] ones;
  } dec_t;

  // value / 10 by reciprocal, exact for 0..127
  function automatic dec_t split_dec(input logic [CountW-1:0] v);
    logic [14:0]       prod;
    logic [DigitW-1:0] tens;
    logic [CountW-1:0] rem;
    dec_t              res;
    prod     = 15'(v) * 15'd205;
    tens     = prod[14:11];
    rem      = v - 7'(tens) * 7'd10;
    res.tens = tens;
    res.ones = rem[DigitW-1:0];
    return res;
  endfunction

endpackage

/* rtl/kct_fsm.sv */
module kct_fsm #(
  parameter int unsigned NUM_KEYS = kct_pkg::NumKeysDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [kct_pkg::KeyW-1:0] key_code_i,
  input  logic                     key_level_i,
  input  kct_pkg::cfg_t            cfg_i,
  output kct_pkg::emit_t           emit_o
);

  kct_pkg::state_e                 state_q, state_d;
  logic [kct_pkg::KeyW-1:0]        held_key_q, held_key_d;
  logic [kct_pkg::TickW-1:0]       elapsed_q, elapsed_d;
  logic                            clear;
  logic                            long_hit;
  logic                            gap_hit;
  logic                            key_ok;

  assign long_hit = elapsed_q >= cfg_i.long_press;
  assign gap_hit  = elapsed_q >= cfg_i.double_gap;
  assign key_ok   = (key_code_i != '0) &&
                    ({28'd0, key_code_i} <= 32'(NUM_KEYS));

  // next state
  always_comb begin
    state_d    = state_q;
    held_key_d = held_key_q;
    clear      = 1'b0;
    unique case (state_q)
      kct_pkg::ST_IDLE: begin
        if (key_ok) begin
          held_key_d = key_code_i;
          state_d    = kct_pkg::ST_ARM;
        end
      end
      kct_pkg::ST_ARM: begin
        if (!key_level_i) state_d = kct_pkg::ST_DEBOUNCE;
      end
      kct_pkg::ST_DEBOUNCE: begin
        if (key_level_i) begin
          state_d = kct_pkg::ST_ARM;
        end else begin
          state_d = kct_pkg::ST_HELD;
          clear   = 1'b1;
        end
      end
      kct_pkg::ST_HELD: begin
        if (long_hit)         state_d = kct_pkg::ST_LONG;
        else if (key_level_i) state_d = kct_pkg::ST_REL_CHK;
      end
      kct_pkg::ST_REL_CHK: begin
        if (key_level_i) begin
          state_d = kct_pkg::ST_GAP;
          clear   = 1'b1;
        end else begin
          state_d = kct_pkg::ST_HELD;
        end
      end
      kct_pkg::ST_GAP: begin
        if (gap_hit)           state_d = kct_pkg::ST_SINGLE;
        else if (!key_level_i) state_d = kct_pkg::ST_PRESS2_CHK;
      end
      kct_pkg::ST_SINGLE:     state_d = kct_pkg::ST_IDLE;
      kct_pkg::ST_PRESS2_CHK: state_d = key_level_i ? kct_pkg::ST_GAP : kct_pkg::ST_DOUBLE;
      kct_pkg::ST_DOUBLE:     state_d = kct_pkg::ST_WAIT_REL_D;
      kct_pkg::ST_WAIT_REL_D: begin
        if (key_level_i) state_d = kct_pkg::ST_REL_D_CHK;
      end
      kct_pkg::ST_REL_D_CHK:  state_d = key_level_i ? kct_pkg::ST_DONE : kct_pkg::ST_WAIT_REL_D;
      kct_pkg::ST_LONG:       state_d = kct_pkg::ST_WAIT_REL_L;
      kct_pkg::ST_WAIT_REL_L: begin
        if (key_level_i) state_d = kct_pkg::ST_REL_L_CHK;
      end
      kct_pkg::ST_REL_L_CHK:  state_d = key_level_i ? kct_pkg::ST_DONE : kct_pkg::ST_WAIT_REL_L;
      default:                state_d = kct_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit_o.valid = 1'b0;
    emit_o.kind  = kct_pkg::KIND_SINGLE;
    emit_o.key   = held_key_q;
    unique case (state_q)
      kct_pkg::ST_SINGLE: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = kct_pkg::KIND_SINGLE;
      end
      kct_pkg::ST_DOUBLE: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = kct_pkg::KIND_DOUBLE;
      end
      kct_pkg::ST_LONG: begin
        emit_o.valid = 1'b1;
        emit_o.kind  = kct_pkg::KIND_LONG;
      end
      default: begin
        emit_o.valid = 1'b0;
      end
    endcase
  end

  // saturating tick counter
  always_comb begin
    if (clear)                 elapsed_d = '0;
    else if (elapsed_q != '1)  elapsed_d = elapsed_q + 1'b1;
    else                       elapsed_d = elapsed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kct_pkg::ST_IDLE;
      held_key_q <= '0;
      elapsed_q  <= '0;
    end else if (fire_i) begin
      state_q    <= state_d;
      held_key_q <= held_key_d;
      elapsed_q  <= elapsed_d;
    end
  end

  a_clear_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && state_q == kct_pkg::ST_DEBOUNCE && !key_level_i |=> elapsed_q == '0)
    else $error("tick counter not cleared at press confirm");

  a_key_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(held_key_q) |-> $past(state_q) == kct_pkg::ST_IDLE)
    else $error("held key changed outside idle");

  a_double_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && state_q == kct_pkg::ST_DOUBLE |=> state_q == kct_pkg::ST_WAIT_REL_D)
    else $error("double click not followed by release wait");

endmodule

/* rtl/kct_counts.sv */
module kct_counts #(
  parameter int unsigned NUM_KEYS = kct_pkg::NumKeysDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  kct_pkg::emit_t             emit_i,
  output kct_pkg::dec_t              key_dec_o,
  output kct_pkg::dec_t              count_dec_o
);

  localparam int unsigned IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  logic [kct_pkg::CountW-1:0] counts_q [NUM_KEYS];
  logic [kct_pkg::KeyW-1:0]   key_m1;
  logic [IdxW-1:0]            idx;
  logic                       in_range;
  logic [kct_pkg::CountW-1:0] cur;
  logic [kct_pkg::CountW-1:0] base;
  logic [kct_pkg::CountW-1:0] upd;

  assign key_m1   = emit_i.key - 1'b1;
  assign in_range = (emit_i.key != '0) &&
                    ({28'd0, emit_i.key} <= 32'(NUM_KEYS));
  assign idx      = in_range ? key_m1[IdxW-1:0] : '0;
  assign cur      = counts_q[idx];
  assign base     = (cur >= kct_pkg::CountWrap) ? '0 : cur;
  assign upd      = base + 7'(emit_i.kind) + 7'd1;

  assign count_dec_o = kct_pkg::split_dec(upd);
  assign key_dec_o   = kct_pkg::split_dec(7'(emit_i.key));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM_KEYS); i++) counts_q[i] <= '0;
    end else if (fire_i && emit_i.valid) begin
      counts_q[idx] <= upd;
    end
  end

endmodule

/* rtl/key_click_type_classifier.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   key_code_i, key_level_i
// out      output     out_valid_o / out_stall_i click_kind_o, key_tens_o, key_ones_o,
//                                               count_tens_o, count_ones_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle while in_stall_o is low; a classification result is taken into the
// output register when an item is accepted while the FSM is in a result state.
// The FSM step and the press-count read-modify-write finish in the accept cycle.
// in_stall_o is high only while a result sits in the output register and
// out_stall_i holds it.
// Reset clears state, tick counter, all press counts and loads the limit defaults.
module key_click_type_classifier #(
  parameter int unsigned NUM_KEYS = kct_pkg::NumKeysDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kct_pkg::KeyW-1:0]      key_code_i,
  input  logic                          key_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kct_pkg::KindW-1:0]     click_kind_o,
  output logic                          key_tens_o,
  output logic [kct_pkg::DigitW-1:0]    key_ones_o,
  output logic [kct_pkg::DigitW-1:0]    count_tens_o,
  output logic [kct_pkg::DigitW-1:0]    count_ones_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [kct_pkg::TickW-1:0]     cfg_data_i
);

  kct_pkg::cfg_t                 cfg_q;
  kct_pkg::emit_t                emit;
  kct_pkg::dec_t                 key_dec;
  kct_pkg::dec_t                 count_dec;
  logic                          fire;
  logic                          out_valid_q;
  logic [kct_pkg::KindW-1:0]     kind_q;
  logic                          key_tens_q;
  logic [kct_pkg::DigitW-1:0]    key_ones_q;
  logic [kct_pkg::DigitW-1:0]    count_tens_q;
  logic [kct_pkg::DigitW-1:0]    count_ones_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign fire        = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press <= kct_pkg::LongPressReset;
      cfg_q.double_gap <= kct_pkg::DoubleGapReset;
    end else if (cfg_valid_i) begin
      unique case (kct_pkg::cfg_idx_e'(cfg_index_i))
        kct_pkg::CFG_LONG_PRESS: cfg_q.long_press <= cfg_data_i;
        kct_pkg::CFG_DOUBLE_GAP: cfg_q.double_gap <= cfg_data_i;
        default:                 cfg_q            <= cfg_q;
      endcase
    end
  end

  kct_fsm #(.NUM_KEYS(NUM_KEYS)) u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .key_code_i (key_code_i),
    .key_level_i(key_level_i),
    .cfg_i      (cfg_q),
    .emit_o     (emit)
  );

  kct_counts #(.NUM_KEYS(NUM_KEYS)) u_counts (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .emit_i     (emit),
    .key_dec_o  (key_dec),
    .count_dec_o(count_dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit.valid) begin
      kind_q       <= emit.kind;
      key_tens_q   <= key_dec.tens[0];
      key_ones_q   <= key_dec.ones;
      count_tens_q <= count_dec.tens;
      count_ones_q <= count_dec.ones;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign click_kind_o = kind_q;
  assign key_tens_o   = key_tens_q;
  assign key_ones_o   = key_ones_q;
  assign count_tens_o = count_tens_q;
  assign count_ones_o = count_ones_q;

endmodule
